### hdl/fpt_pkg.sv
`default_nettype none
package fpt_pkg;

  localparam int PacketsPerFrame = 128;

  localparam int CfgAddrWidth = 5;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DET_WIDTH       = 3'd0,
    REG_MOD_INDEX_X     = 3'd1,
    REG_MOD_INDEX_Y     = 3'd2,
    REG_MOD_HEIGHT      = 3'd3,
    REG_PKT_LINES       = 3'd4,
    REG_FRAME_LIMIT     = 3'd5,
    REG_TIMEOUT_SECONDS = 3'd6
  } cfg_reg_e;

  localparam logic [12:0] DetWidthReset       = 13'd1024;
  localparam logic [3:0]  ModIndexXReset      = 4'd0;
  localparam logic [3:0]  ModIndexYReset      = 4'd0;
  localparam logic [10:0] ModHeightReset      = 11'd512;
  localparam logic [12:0] PktLinesReset       = 13'd4;
  localparam logic [31:0] FrameLimitReset     = 32'hFFFF_FFFF;
  localparam logic [15:0] TimeoutReset        = 16'd10;

  // input command codes
  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_MUL5,
    ST_DONE
  } fpt_state_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    acc_op_e acc_op;
  } mac_ctrl_t;

  typedef struct packed {
    logic [12:0] det_width;
    logic [3:0]  mod_index_x;
    logic [3:0]  mod_index_y;
    logic [10:0] mod_height;
    logic [12:0] pkt_lines;
    logic [31:0] frame_limit;
    logic [15:0] timeout_seconds;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [63:0] frame_number;
    logic [6:0]  packet_number;
    logic [63:0] bunch_id;
    logic [31:0] debug_word;
  } in_t;

  typedef struct packed {
    logic [63:0]        out_frame_number;
    logic signed [7:0]  lost_in_frame;
    logic [63:0]        received_low;
    logic [63:0]        received_high;
    logic [63:0]        out_bunch_id;
    logic [31:0]        out_debug;
    logic [31:0]        first_element;
    logic [15:0]        header_index;
    logic               commit_previous;
    logic               claim_new;
    logic               commit_current;
    logic               stopped;
  } out_t;

endpackage
`default_nettype wire

### hdl/detector_packet_frame_tracker.sv
// packet header: after the input transfer the sequencer steps through ST_MUL0..ST_MUL5, six
// passes through the shared 32x32 multiply-accumulate, then loads the result in ST_DONE
// tick or stopped input: the result (if any) is loaded in ST_DONE; input is taken only in ST_IDLE
// the output register lets a new input transfer happen while a result waits
// reset (rst_ni low, asynchronous) loads register defaults and clears all tracker state
`default_nettype none
module detector_packet_frame_tracker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fpt_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire fpt_pkg::in_t                     in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output fpt_pkg::out_t                         out_o
);
  import fpt_pkg::*;

  cfg_t        cfg;
  fpt_state_e  state_q, state_d;
  mac_ctrl_t   mac_ctrl;
  logic [31:0] mac_a, mac_b, mac_prod, mac_acc;
  logic        in_xfer, load_out;

  // tracker state
  logic [63:0]  last_frame_q, last_frame_d;
  logic         slot_held_q, slot_held_d;
  logic [7:0]   count_q, count_d;
  logic [127:0] map_q, map_d;
  logic [31:0]  frames_q, frames_d;
  logic [15:0]  idle_q, idle_d;
  logic         halted_q, halted_d;

  // item in progress
  out_t        res_q, res_d;
  logic        is_pkt_q, is_pkt_d;
  logic        has_res_q, has_res_d;
  logic [6:0]  pnum_q, pnum_d;
  logic [15:0] hidx_q, hidx_d;
  logic        out_valid_q;
  out_t        out_q, out_d;

  // per-transfer helpers
  logic         halt_now, new_frame;
  logic [15:0]  idle_inc;
  logic [7:0]   cnt_base, cnt_new;
  logic [127:0] map_base, map_new;
  logic [31:0]  line_idx;

  fpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fpt_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod),
    .acc_o  (mac_acc)
  );

  assign in_xfer  = in_valid_i && in_ready_o;
  assign line_idx = 32'(PacketsPerFrame - 1) - 32'(pnum_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = is_pkt_d ? ST_MUL0 : ST_DONE;
        end
      end
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_MUL5;
      ST_MUL5: state_d = ST_DONE;
      ST_DONE: begin
        if (!has_res_q || !out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  // origin = dw*mx*mh + my*dw, then + lpp*line*dw
  always_comb begin
    in_ready_o      = 1'b0;
    load_out        = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    mac_a           = '0;
    mac_b           = '0;
    hidx_d          = hidx_q;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_MUL0: begin
        mac_a = 32'(cfg.det_width);
        mac_b = 32'(cfg.mod_index_x);
      end
      ST_MUL1: begin
        mac_a = mac_prod;
        mac_b = 32'(cfg.mod_height);
      end
      ST_MUL2: begin
        mac_a           = 32'(cfg.mod_index_y);
        mac_b           = 32'(cfg.det_width);
        mac_ctrl.acc_op = ACC_LOAD;
      end
      ST_MUL3: begin
        mac_a           = 32'(cfg.pkt_lines);
        mac_b           = line_idx;
        mac_ctrl.acc_op = ACC_ADD;
        hidx_d          = 16'(cfg.mod_index_x) + mac_prod[15:0];
      end
      ST_MUL4: begin
        mac_a = mac_prod;
        mac_b = 32'(cfg.det_width);
      end
      ST_MUL5: mac_ctrl.acc_op = ACC_ADD;
      ST_DONE: load_out = has_res_q && (!out_valid_q || out_ready_i);
      default: in_ready_o = 1'b0;
    endcase
  end

  // tracker update on an input transfer
  always_comb begin
    last_frame_d = last_frame_q;
    slot_held_d  = slot_held_q;
    count_d      = count_q;
    map_d        = map_q;
    frames_d     = frames_q;
    idle_d       = idle_q;
    halted_d     = halted_q;
    res_d        = res_q;
    is_pkt_d     = is_pkt_q;
    has_res_d    = has_res_q;
    pnum_d       = pnum_q;

    halt_now  = halted_q || ((cfg.frame_limit != '1) && (frames_q >= cfg.frame_limit));
    idle_inc  = (idle_q != '1) ? idle_q + 16'd1 : idle_q;
    new_frame = (last_frame_q != '0) && (in_i.frame_number != last_frame_q);
    cnt_base  = new_frame ? '0 : count_q;
    cnt_new   = (cnt_base != '1) ? cnt_base + 8'd1 : cnt_base;
    map_base  = new_frame ? '0 : map_q;
    map_new   = map_base ^ (128'd1 << in_i.packet_number);

    if (in_xfer) begin
      res_d     = '0;
      is_pkt_d  = 1'b0;
      has_res_d = 1'b1;
      pnum_d    = in_i.packet_number;
      if (halt_now) begin
        halted_d      = 1'b1;
        res_d.stopped = 1'b1;
      end else if (in_i.command == CMD_TICK) begin
        idle_d = idle_inc;
        if (idle_inc > cfg.timeout_seconds) begin
          halted_d              = 1'b1;
          res_d.stopped         = 1'b1;
          res_d.commit_previous = slot_held_q;
        end else begin
          has_res_d = 1'b0;
        end
      end else begin
        is_pkt_d    = 1'b1;
        idle_d      = '0;
        slot_held_d = 1'b1;
        count_d     = cnt_new;
        map_d       = map_new;
        if (last_frame_q == '0 || new_frame) begin
          last_frame_d = in_i.frame_number;
        end
        if (new_frame && frames_q != '1) begin
          frames_d = frames_q + 32'd1;
        end
        res_d.out_frame_number = in_i.frame_number;
        res_d.lost_in_frame    = 8'(PacketsPerFrame) - cnt_new;
        res_d.received_low     = map_new[63:0];
        res_d.received_high    = map_new[127:64];
        res_d.out_bunch_id     = in_i.bunch_id;
        res_d.out_debug        = in_i.debug_word;
        res_d.commit_previous  = new_frame && (count_q != 8'(PacketsPerFrame));
        res_d.claim_new        = !slot_held_q || new_frame;
        res_d.commit_current   = (cnt_new == 8'(PacketsPerFrame));
      end
    end
  end

  always_comb begin
    out_d               = res_q;
    out_d.first_element = is_pkt_q ? mac_acc : '0;
    out_d.header_index  = is_pkt_q ? hidx_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_frame_q <= '0;
      slot_held_q  <= 1'b0;
      count_q      <= '0;
      map_q        <= '0;
      frames_q     <= '0;
      idle_q       <= '0;
      halted_q     <= 1'b0;
      is_pkt_q     <= 1'b0;
      has_res_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      last_frame_q <= last_frame_d;
      slot_held_q  <= slot_held_d;
      count_q      <= count_d;
      map_q        <= map_d;
      frames_q     <= frames_d;
      idle_q       <= idle_d;
      halted_q     <= halted_d;
      is_pkt_q     <= is_pkt_d;
      has_res_q    <= has_res_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pnum_q <= pnum_d;
    hidx_q <= hidx_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");

  a_frames_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(!rst_ni) |-> frames_q >= $past(frames_q))
    else $error("frame counter went down");

  a_stop_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.stopped) |->
      (!out_o.claim_new && !out_o.commit_current && out_o.first_element == '0))
    else $error("stopped result carries packet fields");

  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done step");

endmodule
`default_nettype wire

### hdl/fpt_mac.sv
`default_nettype none
module fpt_mac (
  input  wire logic              clk_i,
  input  wire fpt_pkg::mac_ctrl_t ctrl_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  output logic [31:0]            prod_o,
  output logic [31:0]            acc_o
);
  import fpt_pkg::*;

  logic [31:0] prod_q, prod_d;
  logic [31:0] acc_q, acc_d;

  // products wrap modulo 2^32
  assign prod_d = 32'(a_i * b_i);

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = prod_q;
      ACC_ADD:  acc_d = acc_q + prod_q;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

### hdl/fpt_cfg.sv
`default_nettype none
module fpt_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fpt_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  output fpt_pkg::cfg_t                         cfg_o
);
  import fpt_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CfgAddrWidth-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_DET_WIDTH:        cfg_d.det_width        = pwdata[12:0];
        REG_MOD_INDEX_X:      cfg_d.mod_index_x      = pwdata[3:0];
        REG_MOD_INDEX_Y:      cfg_d.mod_index_y      = pwdata[3:0];
        REG_MOD_HEIGHT:       cfg_d.mod_height       = pwdata[10:0];
        REG_PKT_LINES:        cfg_d.pkt_lines        = pwdata[12:0];
        REG_FRAME_LIMIT:      cfg_d.frame_limit      = pwdata;
        REG_TIMEOUT_SECONDS:  cfg_d.timeout_seconds  = pwdata[15:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DET_WIDTH:        prdata = 32'(cfg_q.det_width);
      REG_MOD_INDEX_X:      prdata = 32'(cfg_q.mod_index_x);
      REG_MOD_INDEX_Y:      prdata = 32'(cfg_q.mod_index_y);
      REG_MOD_HEIGHT:       prdata = 32'(cfg_q.mod_height);
      REG_PKT_LINES:        prdata = 32'(cfg_q.pkt_lines);
      REG_FRAME_LIMIT:      prdata = cfg_q.frame_limit;
      REG_TIMEOUT_SECONDS:  prdata = 32'(cfg_q.timeout_seconds);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.det_width        <= DetWidthReset;
      cfg_q.mod_index_x      <= ModIndexXReset;
      cfg_q.mod_index_y      <= ModIndexYReset;
      cfg_q.mod_height       <= ModHeightReset;
      cfg_q.pkt_lines        <= PktLinesReset;
      cfg_q.frame_limit      <= FrameLimitReset;
      cfg_q.timeout_seconds  <= TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire
